### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rgbs_pkg.sv
package rgbs_pkg;

  // Field widths
  localparam int IDX_W      = 20;
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 16;
  localparam int VAR_W      = 24;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  // Wide enough to compare an index against the largest frame size
  localparam int IDX_CMP_W  = 23;

  localparam int FRAME_PIXELS_DEFAULT = 921600;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] INITIAL_RATE_RST = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] RATE_DECAY_RST   = 16'd62259;
  localparam logic [CFG_DATA_W-1:0] RATE_FLOOR_RST   = 16'd3277;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST    = 16'd1600;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_UPDATE  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_RATE = 2'd0,
    CFG_RATE_DECAY   = 2'd1,
    CFG_RATE_FLOOR   = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_reg_t;

  // One model entry as stored in memory
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic              mask;
  } entry_t;

  // Control of one pixel moving down the pipeline
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic             inr;
  } item_t;

  // Write-back to the model memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wb_t;

  // Classification result
  typedef struct packed {
    logic             valid;
    logic             fg;
    logic [IDX_W-1:0] idx;
  } res_t;

endpackage

### rtl/rgbs_pipe.sv
module rgbs_pipe
  import rgbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  item_t             in_item,
  input  entry_t            rd_entry,
  input  logic [RATE_W-1:0] rate,
  input  logic [CFG_DATA_W-1:0] threshold,
  input  logic [IDX_W-1:0]  probe_idx,
  output logic              hit,
  output wb_t               wb,
  output res_t              res
);

  localparam int STAGES = 7;

  function automatic logic [MEAN_W-1:0] absdiff(input logic [MEAN_W-1:0] a,
                                                 input logic [MEAN_W-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [STAGES-1:0] vld;
  item_t             ctl [STAGES];

  // Advance valid bits and item control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= in_item;
      for (int k = 1; k < STAGES; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // Flag any in-flight pixel at the probed position
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < STAGES; k++) begin
      if (vld[k] && (ctl[k].idx == probe_idx)) hit = 1'b1;
    end
  end

  // Stage 1: distance to old mean, mean blend products
  logic [MEAN_W-1:0] pix_q1, d0_1;
  logic [RATE_W:0]   p_inv1;
  logic [32:0]       ma_1;
  logic [23:0]       mb_1;

  assign pix_q1 = {ctl[0].pix, 8'b0};
  assign d0_1   = absdiff(pix_q1, rd_entry.mean);
  assign p_inv1 = 17'h10000 - {1'b0, rate};
  assign ma_1   = 33'(p_inv1) * 33'(rd_entry.mean);
  assign mb_1   = 24'(rate) * 24'(ctl[0].pix);

  logic [RATE_W-1:0] p_2;
  entry_t            ent_2;
  logic [32:0]       ma_2;
  logic [23:0]       mb_2;
  logic [MEAN_W-1:0] d0_2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_2   <= rate;
      ent_2 <= rd_entry;
      ma_2  <= ma_1;
      mb_2  <= mb_1;
      d0_2  <= d0_1;
    end
  end

  // Stage 2: round the mean blend, pick new mean, square old distance
  logic [33:0]       msum_2;
  logic [MEAN_W-1:0] mblend_2, mean_sel_2;
  logic [31:0]       d0sq_2;

  assign msum_2   = 34'(ma_2) + 34'({mb_2, 8'b0}) + 34'(32768);
  assign mblend_2 = msum_2[31:16];
  assign d0sq_2   = 32'(d0_2) * 32'(d0_2);

  always_comb begin
    case (ctl[1].op)
      OP_LOAD: mean_sel_2 = {ctl[1].pix, 8'b0};
      default: mean_sel_2 = ent_2.mask ? ent_2.mean : mblend_2;
    endcase
  end

  logic [RATE_W-1:0] p_3;
  entry_t            ent_3;
  logic [31:0]       d0sq_3;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_3    <= p_2;
      ent_3  <= '{mean: mean_sel_2, variance: ent_2.variance, mask: ent_2.mask};
      d0sq_3 <= d0sq_2;
    end
  end

  // Stage 3: square distance to new mean
  logic [MEAN_W-1:0] d1_3;
  logic [31:0]       d1sq_3;

  assign d1_3   = absdiff({ctl[2].pix, 8'b0}, ent_3.mean);
  assign d1sq_3 = 32'(d1_3) * 32'(d1_3);

  logic [RATE_W-1:0] p_4;
  entry_t            ent_4;
  logic [31:0]       d0sq_4, d1sq_4;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_4    <= p_3;
      ent_4  <= ent_3;
      d0sq_4 <= d0sq_3;
      d1sq_4 <= d1sq_3;
    end
  end

  // Stage 4: round squared distance to Q16.8, variance blend products
  logic [31:0]      tsq_4, trnd_4;
  logic [VAR_W-1:0] target_4;
  logic [RATE_W:0]  p_inv4;
  logic [40:0]      va_4;
  logic [39:0]      vb_4;

  assign tsq_4    = (ctl[3].op == OP_EXTRACT) ? d0sq_4 : d1sq_4;
  assign trnd_4   = tsq_4 + 32'd128;
  assign target_4 = trnd_4[31:8];
  assign p_inv4   = 17'h10000 - {1'b0, p_4};
  assign va_4     = 41'(p_inv4) * 41'(ent_4.variance);
  assign vb_4     = 40'(p_4) * 40'(target_4);

  entry_t      ent_5;
  logic [31:0] d0sq_5;
  logic [40:0] va_5;
  logic [39:0] vb_5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_5  <= ent_4;
      d0sq_5 <= d0sq_4;
      va_5   <= va_4;
      vb_5   <= vb_4;
    end
  end

  // Stage 5: round the variance blend, pick new variance
  logic [41:0]      vsum_5;
  logic [VAR_W-1:0] vblend_5, var_sel_5;

  assign vsum_5   = 42'(va_5) + 42'(vb_5) + 42'(32768);
  assign vblend_5 = vsum_5[39:16];

  always_comb begin
    case (ctl[4].op)
      OP_LOAD:    var_sel_5 = '0;
      OP_EXTRACT: var_sel_5 = ent_5.mask ? ent_5.variance : vblend_5;
      default:    var_sel_5 = vblend_5;
    endcase
  end

  entry_t      ent_6;
  logic [31:0] d0sq_6;

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_6  <= '{mean: ent_5.mean, variance: var_sel_5, mask: ent_5.mask};
      d0sq_6 <= d0sq_5;
    end
  end

  // Stage 6: scale variance by squared threshold
  logic [39:0] tv_6;

  assign tv_6 = 40'(threshold) * 40'(ent_6.variance);

  entry_t      ent_7;
  logic [31:0] d0sq_7;
  logic [39:0] tv_7;

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_7  <= ent_6;
      d0sq_7 <= d0sq_6;
      tv_7   <= tv_6;
    end
  end

  // Stage 7: classify, form write-back and result
  logic fg_7, mask_wr_7, op_ok_7;

  assign fg_7 = 40'(d0sq_7) > tv_7;

  always_comb begin
    case (ctl[6].op)
      OP_LOAD:    begin mask_wr_7 = 1'b0;        op_ok_7 = 1'b1; end
      OP_EXTRACT: begin mask_wr_7 = fg_7;        op_ok_7 = 1'b1; end
      OP_UPDATE:  begin mask_wr_7 = ent_7.mask;  op_ok_7 = 1'b1; end
      default:    begin mask_wr_7 = ent_7.mask;  op_ok_7 = 1'b0; end
    endcase
  end

  assign wb.we    = vld[STAGES-1] && ctl[6].inr && op_ok_7;
  assign wb.idx   = ctl[6].idx;
  assign wb.entry = '{mean: ent_7.mean, variance: ent_7.variance, mask: mask_wr_7};

  assign res.valid = vld[STAGES-1] && (ctl[6].op == OP_EXTRACT);
  assign res.fg    = ctl[6].inr && fg_7;
  assign res.idx   = ctl[6].idx;

endmodule

### rtl/running_gaussian_background_subtract.sv
// Running Gaussian average background subtraction, one model entry per pixel.
// Input beats on s_*: tuser carries opcode and frame_start, tdata carries
// pixel_index and pixel. Load seeds an entry, update adapts it, extract adapts
// background entries and returns one beat on m_* with the foreground bit and
// the pixel's index. Load and update return nothing.
// Registers are written over cfg_* (index, 16-bit data); write them only
// while no pixel is in flight.
// Throughput: one pixel per cycle while no pixel in flight touches the same
// entry and results can leave. The model memory is read when a beat is
// accepted and written back from the last stage, so a pixel whose index
// matches one of the previous seven still in flight waits until that one is
// written back. An extract result reaches m_tvalid through the output register.
// The output register holds a result while m_tready is low; input beats keep
// flowing until the next result reaches the last stage, then the whole
// pipeline holds.
// Reset clears the pipeline, the output beat and the registers (learning rate
// back to 0.5). Model memory is not cleared: load every pixel before use.
module running_gaussian_background_subtract
  import rgbs_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [19:0] pixel_index, [27:20] pixel
  input  logic [IN_USER_W-1:0]  s_tuser,   // [1:0] opcode, [2] frame_start
  // result output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [0] foreground, [20:1] result_index
);

  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic [CFG_DATA_W-1:0] initial_rate, rate_decay, rate_floor, threshold_squared;
  logic [RATE_W-1:0]     learning_rate;

  logic   adv, hit, accept;
  item_t  in_item;
  entry_t rd_entry;
  wb_t    wb;
  res_t   res;

  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            mem [FRAME_PIXELS];

  logic              out_fg;
  logic [IDX_W-1:0]  out_idx;

  // Unpack the input beat
  assign in_item.op  = op_t'(s_tuser[1:0]);
  assign in_item.idx = s_tdata[IDX_W-1:0];
  assign in_item.pix = s_tdata[IDX_W+PIX_W-1:IDX_W];
  assign in_item.inr = IDX_CMP_W'(in_item.idx) < IDX_CMP_W'(FRAME_PIXELS);

  // Hold everything when a finished result cannot leave
  assign adv      = !(res.valid && m_tvalid && !m_tready);
  assign s_tready = adv && !hit;
  assign accept   = s_tvalid && s_tready;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_rate      <= INITIAL_RATE_RST;
      rate_decay        <= RATE_DECAY_RST;
      rate_floor        <= RATE_FLOOR_RST;
      threshold_squared <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_INITIAL_RATE: initial_rate      <= cfg_data;
        CFG_RATE_DECAY:   rate_decay        <= cfg_data;
        CFG_RATE_FLOOR:   rate_floor        <= cfg_data;
        CFG_THRESHOLD:    threshold_squared <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Learning rate: reload on load frame start, decay on extract frame start while above the floor
  logic [31:0]       decay_prod;
  logic [RATE_W-1:0] learning_rate_next;

  assign decay_prod = 32'(learning_rate) * 32'(rate_decay) + 32'd32768;

  always_comb begin
    learning_rate_next = learning_rate;
    if (accept && s_tuser[2]) begin
      case (in_item.op)
        OP_LOAD:    learning_rate_next = initial_rate;
        OP_EXTRACT: if (learning_rate > rate_floor) learning_rate_next = decay_prod[31:16];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) learning_rate <= INITIAL_RATE_RST;
    else     learning_rate <= learning_rate_next;
  end

  // Model memory: read whenever the pipeline advances, write back from the last stage
  assign rd_addr = ADDR_W'(in_item.idx);
  assign wr_addr = ADDR_W'(wb.idx);

  always_ff @(posedge clk) begin
    if (adv) rd_entry <= mem[rd_addr];
    if (adv && wb.we) mem[wr_addr] <= wb.entry;
  end

  rgbs_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (accept),
    .in_item   (in_item),
    .rd_entry  (rd_entry),
    .rate      (learning_rate),
    .threshold (threshold_squared),
    .probe_idx (in_item.idx),
    .hit       (hit),
    .wb        (wb),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_fg  <= res.fg;
      out_idx <= res.idx;
    end
  end

  assign m_tdata = {(OUT_DATA_W-IDX_W-1)'(0), out_idx, out_fg};

endmodule

### rtl/rgbs_checker.sv
`include "assert_macros.svh"

module rgbs_checker
  import rgbs_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result beat keeps its payload
  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // Reset drops any pending result
  `CHK_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !m_tvalid, "result beat survived reset")

  // Pixels outside the frame are never foreground
  `CHK_ASSERT(a_oob_bg, clk, rst, m_tvalid && (IDX_CMP_W'(m_tdata[IDX_W:1]) >= IDX_CMP_W'(FRAME_PIXELS)) |-> !m_tdata[0], "out-of-frame pixel marked foreground")

  // Padding bits of the result stay zero
  `CHK_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[OUT_DATA_W-1:IDX_W+1] == '0), "result padding not zero")

endmodule

bind running_gaussian_background_subtract rgbs_checker #(
  .FRAME_PIXELS(FRAME_PIXELS)
) u_rgbs_checker (.*);

### sim/tb_running_gaussian_background_subtract.sv
module tb_running_gaussian_background_subtract;
  import rgbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_SIZE    = FRAME_PIXELS_DEFAULT;
  localparam int POOL          = 40;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BEATS   = 120;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  // Opcode that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {WANT_MODEL, WANT_BG, WANT_FG} want_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [1:0]            op;
    logic                  fs;
    logic [IDX_W-1:0]      idx;
    logic [PIX_W-1:0]      pix;
    want_t                 want;
    cfg_reg_t              sel;
    logic [CFG_DATA_W-1:0] val;
  } row_t;

  typedef struct packed {
    logic             fg;
    logic [IDX_W-1:0] idx;
  } mask_beat_t;

  localparam int NUM_ROWS = 25;

  // Directed rows: extremes, every opcode, out-of-range index, zero variance
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_PIXEL, OP_LOAD,    1'b1, 20'd0,      8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_LOAD,    1'b0, 20'd921599, 8'd255,  WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_LOAD,    1'b0, 20'h5A5A5,  8'hA5,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b1, 20'd0,      8'd0,    WANT_BG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'd921599, 8'd255,  WANT_BG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'd0,      8'd255,  WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UPDATE,  1'b0, 20'h5A5A5,  8'h5A,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'h5A5A5,  8'h5A,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b1, 20'd921600, 8'h7F,   WANT_BG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'hFFFFF,  8'hFF,   WANT_BG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_LOAD,    1'b1, 20'hFFFFF,  8'h01,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UPDATE,  1'b0, 20'hFFFFF,  8'h03,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UNUSED,  1'b1, 20'd0,      8'hC8,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UPDATE,  1'b0, 20'd921599, 8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'd921599, 8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_REG,   OP_LOAD,    1'b0, 20'd0,      8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_LOAD,    1'b1, 20'd5,      8'd100,  WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    // rate is zero: variance stays zero, any nonzero distance is foreground
    '{ROW_PIXEL, OP_EXTRACT, 1'b1, 20'd5,      8'd101,  WANT_FG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'd5,      8'd100,  WANT_BG,    CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UPDATE,  1'b0, 20'd5,      8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_REG,   OP_LOAD,    1'b0, 20'd0,      8'd0,    WANT_MODEL, CFG_THRESHOLD,    16'hFFFF},
    '{ROW_REG,   OP_LOAD,    1'b0, 20'd0,      8'd0,    WANT_MODEL, CFG_INITIAL_RATE, 16'hFFFF},
    '{ROW_PIXEL, OP_LOAD,    1'b1, 20'd7,      8'h55,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_EXTRACT, 1'b0, 20'd7,      8'hAA,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0},
    '{ROW_PIXEL, OP_UPDATE,  1'b0, 20'd7,      8'h00,   WANT_MODEL, CFG_INITIAL_RATE, 16'd0}
  };

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [19:0] pixel_index, [27:20] pixel
  logic [IN_USER_W-1:0]  s_tuser   = '0;   // [1:0] opcode, [2] frame_start
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // [0] foreground, [20:1] result_index

  running_gaussian_background_subtract #(
    .FRAME_PIXELS(FRAME_SIZE)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Shadow of the background model
  logic [MEAN_W-1:0]     mean_mem [int unsigned];
  logic [VAR_W-1:0]      var_mem  [int unsigned];
  logic                  mask_mem [int unsigned];
  logic [RATE_W-1:0]     lr       = INITIAL_RATE_RST;
  logic [CFG_DATA_W-1:0] lr_init  = INITIAL_RATE_RST;
  logic [CFG_DATA_W-1:0] lr_decay = RATE_DECAY_RST;
  logic [CFG_DATA_W-1:0] lr_floor = RATE_FLOOR_RST;
  logic [CFG_DATA_W-1:0] thr_sq   = THRESHOLD_RST;

  mask_beat_t  pending_masks [$];

  // Stimulus pool of in-range pixel positions
  logic [IDX_W-1:0] pool_idx    [POOL];
  logic [PIX_W-1:0] pool_pix    [POOL];
  bit               pool_loaded [POOL];

  int unsigned beats_sent;
  int unsigned masks_checked;
  int unsigned fg_seen;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned sink_hold;
  logic [8:0]  calm_cnt = '0;
  bit          calm     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] blend_q16(input longint unsigned old_v,
                                            input longint unsigned tgt,
                                            input longint unsigned p);
    longint unsigned acc;
    acc = (64'd65536 - p) * old_v + p * tgt + 64'd32768;
    return acc[47:16];
  endfunction

  function automatic logic [MEAN_W-1:0] distance_q88(input logic [PIX_W-1:0] pix,
                                                     input logic [MEAN_W-1:0] mean);
    logic [MEAN_W-1:0] px;
    px = {pix, 8'h00};
    return (px >= mean) ? px - mean : mean - px;
  endfunction

  function automatic logic [31:0] square_q168(input logic [MEAN_W-1:0] d);
    longint unsigned sq;
    sq = longint'(d) * d + 64'd128;
    return sq[39:8];
  endfunction

  // Advance the model by one pixel; report whether a mask beat is due
  task automatic classify_pixel(input logic [1:0] op, input logic fs,
                                input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] pix,
                                output bit emits, output bit fg);
    bit                inr;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  vr;
    logic [MEAN_W-1:0] d;
    longint unsigned   acc;
    inr   = (idx < FRAME_SIZE);
    emits = 1'b0;
    fg    = 1'b0;
    case (op)
      OP_LOAD: begin
        if (fs) lr = lr_init;
        if (inr) begin
          mean_mem[idx] = {pix, 8'h00};
          var_mem[idx]  = '0;
          mask_mem[idx] = 1'b0;
        end
      end
      OP_EXTRACT: begin
        emits = 1'b1;
        if (fs && lr > lr_floor) begin
          acc = longint'(lr) * lr_decay + 64'd32768;
          lr  = acc[31:16];
        end
        if (inr) begin
          mean = mean_mem[idx];
          vr   = var_mem[idx];
          d    = distance_q88(pix, mean);
          if (!mask_mem[idx]) begin
            mean = MEAN_W'(blend_q16(mean, {pix, 8'h00}, lr));
            vr   = VAR_W'(blend_q16(vr, square_q168(d), lr));
            mean_mem[idx] = mean;
            var_mem[idx]  = vr;
          end
          fg = (longint'(d) * d > longint'(thr_sq) * vr);
          mask_mem[idx] = fg;
        end
      end
      OP_UPDATE: begin
        if (inr) begin
          mean = mean_mem[idx];
          if (!mask_mem[idx]) begin
            mean = MEAN_W'(blend_q16(mean, {pix, 8'h00}, lr));
            mean_mem[idx] = mean;
          end
          d = distance_q88(pix, mean);
          var_mem[idx] = VAR_W'(blend_q16(var_mem[idx], square_q168(d), lr));
        end
      end
      default: ;
    endcase
  endtask

  // Present one pixel beat, wait for acceptance, queue the expected mask
  task automatic send_pixel(input logic [1:0] op, input logic fs,
                            input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] pix,
                            input want_t want);
    int         g;
    bit         emits;
    bit         fg;
    mask_beat_t beat;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {fs, op};
    s_tdata  <= {4'h0, pix, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_pixel(op, fs, idx, pix, emits, fg);
    if (op != OP_UNUSED) beats_sent++;
    if (emits) begin
      if (want == WANT_BG) fg = 1'b0;
      else if (want == WANT_FG) fg = 1'b1;
      beat.fg  = fg;
      beat.idx = idx;
      pending_masks = {pending_masks, beat};
    end
  endtask

  // Drain the pipeline before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      CFG_INITIAL_RATE: lr_init  = val;
      CFG_RATE_DECAY:   lr_decay = val;
      CFG_RATE_FLOOR:   lr_floor = val;
      CFG_THRESHOLD:    thr_sq   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Program all four registers; defaults, all-zero, all-one, then random
  task automatic apply_setting(input int phase);
    logic [CFG_DATA_W-1:0] v [4];
    case (phase)
      0: v = '{INITIAL_RATE_RST, RATE_DECAY_RST, RATE_FLOOR_RST, THRESHOLD_RST};
      1: v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
      2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      default: begin
        v[0] = CFG_DATA_W'($urandom_range(0, 65535));
        v[1] = CFG_DATA_W'($urandom_range(40000, 65535));
        v[2] = CFG_DATA_W'($urandom_range(0, 12000));
        v[3] = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                           : CFG_DATA_W'($urandom_range(0, 4000));
      end
    endcase
    for (int r = 0; r < 4; r++) write_reg(cfg_reg_t'(r), v[r]);
  endtask

  function automatic logic [PIX_W-1:0] near_pixel(input logic [PIX_W-1:0] base);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r == 0) return PIX_W'($urandom_range(0, 255));
    if (r <= 5)      v = int'($urandom_range(0, 4)) - 2 + int'(base);
    else if (r <= 8) v = int'($urandom_range(0, 24)) - 12 + int'(base);
    else             v = int'($urandom_range(0, 120)) - 60 + int'(base);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // Out-of-range positions and the unused opcode, sprinkled into frames
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_pixel(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                 IDX_W'($urandom_range(FRAME_SIZE, 20'hFFFFF)),
                 PIX_W'($urandom_range(0, 255)), WANT_MODEL);
    else
      send_pixel(OP_UNUSED, 1'($urandom_range(0, 1)),
                 IDX_W'($urandom_range(0, 20'hFFFFF)),
                 PIX_W'($urandom_range(0, 255)), WANT_MODEL);
  endtask

  // One frame of a single opcode, with noise beats mixed in, walking the pool in slot order
  task automatic run_frame();
    logic [1:0] op;
    int         r;
    int         len;
    int         start;
    int         slot;
    logic       fs_next;
    bit         any_loaded;
    any_loaded = 1'b0;
    foreach (pool_loaded[i]) any_loaded |= pool_loaded[i];
    r  = $urandom_range(0, 99);
    op = (r < 20) ? OP_LOAD : (r < 75) ? OP_EXTRACT : OP_UPDATE;
    if (!any_loaded) op = OP_LOAD;
    len     = $urandom_range(4, 24);
    start   = $urandom_range(0, POOL - 1);
    fs_next = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < len; k++) begin
      slot = (start + k) % POOL;
      if ($urandom_range(0, 99) < 8) send_noise();
      // never touch an entry that was not seeded
      if (op != OP_LOAD && !pool_loaded[slot]) continue;
      pool_pix[slot] = near_pixel(pool_pix[slot]);
      send_pixel(op, fs_next, pool_idx[slot], pool_pix[slot], WANT_MODEL);
      if (op == OP_LOAD) pool_loaded[slot] = 1'b1;
      fs_next = ($urandom_range(0, 49) == 0);
    end
  endtask

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // Toggle calm stretches with no idling on either side
  always @(posedge clk) begin
    calm_cnt <= calm_cnt + 1'b1;
    if (calm_cnt == '0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Result sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      sink_hold <= pick_gap();
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each mask beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      masks_checked++;
      if (m_tdata[0]) fg_seen++;
      if (pending_masks.size() == 0) begin
        log_failure($sformatf("unexpected mask beat: fg %0b idx %0d",
                              m_tdata[0], m_tdata[20:1]));
      end else if (m_tdata[0] !== pending_masks[0].fg ||
                   m_tdata[20:1] !== pending_masks[0].idx) begin
        log_failure($sformatf("mask mismatch: expected fg %0b idx %0d, got fg %0b idx %0d",
                              pending_masks[0].fg, pending_masks[0].idx,
                              m_tdata[0], m_tdata[20:1]));
        void'(pending_masks.pop_front());
      end else begin
        void'(pending_masks.pop_front());
      end
    end
  end

  // Watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d masks pending",
               quiet_cycles, pending_masks.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int target;
    foreach (pool_idx[i]) begin
      if (i == 0)         pool_idx[i] = '0;
      else if (i == 1)    pool_idx[i] = IDX_W'(FRAME_SIZE - 1);
      else if (i % 2 == 0) pool_idx[i] = IDX_W'($urandom_range(0, FRAME_SIZE - 1));
      else                pool_idx[i] = IDX_W'($urandom_range(20'h80000, FRAME_SIZE - 1));
      pool_pix[i]    = PIX_W'($urandom_range(0, 255));
      pool_loaded[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[i].sel, DIRECTED[i].val);
      end else begin
        send_pixel(DIRECTED[i].op, DIRECTED[i].fs, DIRECTED[i].idx,
                   DIRECTED[i].pix, DIRECTED[i].want);
      end
    end

    // Random frames under several register settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      apply_setting(phase);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) run_frame();
    end

    s_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d pixel beats: %0d directed rows, %0d register settings",
             beats_sent, NUM_ROWS, NUM_PHASES);
    $display("checked %0d mask beats, %0d foreground, %0d failures",
             masks_checked, fg_seen, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
